### sv/ofb_pkg.sv
package ofb_pkg;

  // Field widths fixed by the pixel and register formats.
  localparam int COL_W    = 12;
  localparam int CHAN_W   = 8;
  localparam int SPAN_W   = 13;
  localparam int QUOT_W   = CHAN_W;
  // Largest numerator is 255 * 8191, which fits in 21 bits.
  localparam int NUM_W    = CHAN_W + SPAN_W;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  // Products, sum, then one restoring division step per quotient bit.
  localparam int LANE_STAGES = 2 + QUOT_W;

  localparam int MAX_WIDTH_DEF = 4096;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_OVERLAP_START  = 2'd0;
  localparam logic [1:0] REG_NEAR_WIDTH     = 2'd1;
  localparam logic [1:0] REG_DARK_THRESHOLD = 2'd2;

  localparam logic [COL_W-1:0]  OVERLAP_START_RST  = '0;
  localparam logic [SPAN_W-1:0] NEAR_WIDTH_RST     = SPAN_W'(4096);
  localparam logic [CHAN_W-1:0] DARK_THRESHOLD_RST = CHAN_W'(50);

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CHAN_W-1:0] warped_blue;
    logic [CHAN_W-1:0] warped_green;
    logic [CHAN_W-1:0] warped_red;
    logic [CHAN_W-1:0] near_blue;
    logic [CHAN_W-1:0] near_green;
    logic [CHAN_W-1:0] near_red;
  } pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
  } blend_t;

  typedef struct packed {
    logic [COL_W-1:0]  overlap_start;
    logic [SPAN_W-1:0] near_width;
    logic [CHAN_W-1:0] dark_threshold;
  } cfg_t;

  // Divisor and weight of the warped pixel; passthrough uses a divisor of one.
  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] offset;
  } dec_t;

endpackage

### sv/overlap_feather_blend.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+---------------------------
// pix       | in        | pix_valid / pix_stall      | pix_t: column, BGR pairs
// blend     | out       | blend_valid / blend_stall  | blend_t: blended BGR
// apb       | in        | psel / penable / pwrite    | paddr, pwdata, prdata
//
// One request is taken per clock while pix_stall is low; each result passes
// through the input and decode registers, the product and sum stages and the
// eight-step restoring divider in each colour lane, and the output register.
// Reset clears the valid pipeline and the output and skid valid flags, and
// loads the register defaults; no clearing pass is needed.
// While the output is stalled one further result lands in the skid register;
// pix_stall rises only once that skid register is full.
module overlap_feather_blend
  import ofb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  pix_t               pix,
  output logic               blend_valid,
  input  logic               blend_stall,
  output blend_t             blend
);

  // Input register, decode register, then the lane stages.
  localparam int NS = LANE_STAGES + 2;

  cfg_t              cfg;
  pix_t              s0_pix;
  pix_t              s1_pix;
  dec_t              s0_dec;
  dec_t              s1_dec;
  logic [NS-1:0]     v;
  logic              en;
  logic [CHAN_W-1:0] q_blue;
  logic [CHAN_W-1:0] q_green;
  logic [CHAN_W-1:0] q_red;
  blend_t            merged;
  logic              leave;
  logic              skid_v;
  blend_t            skid;

  ofb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The whole pipeline moves as one while the skid register is empty. A
  // full skid register means the output is also held, so freezing is safe.
  assign en        = !skid_v;
  assign pix_stall = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], pix_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pix <= pix;
      s1_pix <= s0_pix;
      s1_dec <= s0_dec;
    end
  end

  // The region test and the dark test need the whole pixel, so they are
  // done once here and shared by the three lanes.
  ofb_decode #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_decode (
    .pix (s0_pix),
    .cfg (cfg),
    .dec (s0_dec)
  );

  ofb_lane u_lane_blue (
    .clk      (clk),
    .en       (en),
    .near_v   (s1_pix.near_blue),
    .warped_v (s1_pix.warped_blue),
    .dec      (s1_dec),
    .quot     (q_blue)
  );

  ofb_lane u_lane_green (
    .clk      (clk),
    .en       (en),
    .near_v   (s1_pix.near_green),
    .warped_v (s1_pix.warped_green),
    .dec      (s1_dec),
    .quot     (q_green)
  );

  ofb_lane u_lane_red (
    .clk      (clk),
    .en       (en),
    .near_v   (s1_pix.near_red),
    .warped_v (s1_pix.warped_red),
    .dec      (s1_dec),
    .quot     (q_red)
  );

  // Merge the three lane quotients into one result.
  assign merged.out_blue  = q_blue;
  assign merged.out_green = q_green;
  assign merged.out_red   = q_red;
  assign leave            = v[NS-1] && en;

  // Output register with a skid register behind it. When the output is
  // held, a result leaving the lanes is parked in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_valid <= 1'b0;
      skid_v      <= 1'b0;
    end else if (!blend_valid || !blend_stall) begin
      blend_valid <= skid_v || leave;
      skid_v      <= 1'b0;
    end else if (leave) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!blend_valid || !blend_stall) begin
      blend <= skid_v ? skid : merged;
    end else if (leave) begin
      skid <= merged;
    end
  end

  // A parked result always sits behind a held one.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> blend_valid)
    else $error("skid register full while output is empty");

  // The divider must never see a zero divisor.
  a_span_nonzero : assert property (@(posedge clk) disable iff (rst)
    v[1] |-> s1_dec.span != '0)
    else $error("zero divisor entered the lanes");

  // A result leaving the lanes is never dropped.
  a_leave_lands : assert property (@(posedge clk) disable iff (rst)
    leave |=> blend_valid)
    else $error("result leaving the lanes was lost");

  // Reset leaves no result pending and the input open.
  a_reset_clean : assert property (@(posedge clk)
    $past(rst) |-> !blend_valid && !pix_stall)
    else $error("state not cleared by reset");

endmodule

### sv/ofb_regs.sv
module ofb_regs
  import ofb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overlap_start  <= OVERLAP_START_RST;
      cfg.near_width     <= NEAR_WIDTH_RST;
      cfg.dark_threshold <= DARK_THRESHOLD_RST;
    end else if (wr) begin
      unique case (idx)
        REG_OVERLAP_START:  cfg.overlap_start  <= pwdata[COL_W-1:0];
        REG_NEAR_WIDTH:     cfg.near_width     <= pwdata[SPAN_W-1:0];
        REG_DARK_THRESHOLD: cfg.dark_threshold <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OVERLAP_START:  prdata = PDATA_W'(cfg.overlap_start);
      REG_NEAR_WIDTH:     prdata = PDATA_W'(cfg.near_width);
      REG_DARK_THRESHOLD: prdata = PDATA_W'(cfg.dark_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

### sv/ofb_decode.sv
module ofb_decode
  import ofb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
  input  pix_t pix,
  input  cfg_t cfg,
  output dec_t dec
);

  localparam logic [SPAN_W+1:0] MaxW = (SPAN_W+2)'(MAX_WIDTH);
  localparam logic [SPAN_W-1:0] SpanOne = SPAN_W'(1);

  logic [SPAN_W+1:0] width_ext;
  logic [SPAN_W+1:0] limit_ext;
  logic [SPAN_W-1:0] limit;
  logic [SPAN_W-1:0] col;
  logic [SPAN_W-1:0] start;
  logic              dark;

  assign width_ext = {2'b00, cfg.near_width};
  assign limit_ext = (width_ext > MaxW) ? MaxW : width_ext;
  assign limit     = limit_ext[SPAN_W-1:0];
  assign col       = {1'b0, pix.column};
  assign start     = {1'b0, cfg.overlap_start};
  assign dark      = (pix.warped_blue  < cfg.dark_threshold) &&
                     (pix.warped_green < cfg.dark_threshold) &&
                     (pix.warped_red   < cfg.dark_threshold);

  // Passthrough cases become a blend with a divisor of one, so that the
  // lanes need no separate bypass path.
  always_comb begin
    if (col < start) begin
      dec.span   = SpanOne;
      dec.offset = '0;
    end else if (col >= limit) begin
      dec.span   = SpanOne;
      dec.offset = SpanOne;
    end else if (dark) begin
      dec.span   = SpanOne;
      dec.offset = '0;
    end else begin
      dec.span   = limit - start;
      dec.offset = col - start;
    end
  end

endmodule

### sv/ofb_lane.sv
module ofb_lane
  import ofb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CHAN_W-1:0] near_v,
  input  logic [CHAN_W-1:0] warped_v,
  input  dec_t              dec,
  output logic [CHAN_W-1:0] quot
);

  logic [NUM_W-1:0]  near_part;
  logic [NUM_W-1:0]  warp_part;
  logic [SPAN_W-1:0] span_p;

  logic [NUM_W-1:0]  rem    [QUOT_W+1];
  logic [SPAN_W-1:0] span_r [QUOT_W+1];
  logic [QUOT_W-1:0] q      [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      near_part <= NUM_W'(near_v) * NUM_W'(dec.span - dec.offset);
      warp_part <= NUM_W'(warped_v) * NUM_W'(dec.offset);
      span_p    <= dec.span;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= near_part + warp_part;
      span_r[0] <= span_p;
      q[0]      <= '0;
    end
  end

  // Restoring division, most significant quotient bit first. The quotient
  // never exceeds 255, so eight steps are enough.
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int Sh = QUOT_W - 1 - j;
    logic [NUM_W-1:0] dvs;
    logic             ge;

    assign dvs = NUM_W'(span_r[j]) << Sh;
    assign ge  = rem[j] >= dvs;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]    <= ge ? (rem[j] - dvs) : rem[j];
        span_r[j+1] <= span_r[j];
        q[j+1]      <= {q[j][QUOT_W-2:0], ge};
      end
    end
  end

  assign quot = q[QUOT_W];

endmodule
